@@ src/six_channel_kalman_smoother_macros.svh @@
// Assertion macros shared by the checker of six_channel_kalman_smoother.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SIX_CHANNEL_KALMAN_SMOOTHER_MACROS_SVH
`define SIX_CHANNEL_KALMAN_SMOOTHER_MACROS_SVH

// Clocked property, switched off while reset is held
`define SCK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Antecedent in this cycle, consequent in the next
`define SCK_ASSERT_NEXT(lbl, ante, cons, msg) \
    `SCK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ src/sck_pkg.sv @@
// Shared types and constants of the six-channel Kalman smoother.
// No dependencies; used by sck_div and six_channel_kalman_smoother.
package sck_pkg;

    // Fixed-point format of variances and samples
    localparam int FRAC_BITS = 16;
    localparam logic [31:0] ONE_Q = 32'(64'(1) << FRAC_BITS);

    // Axis count and index width
    localparam int AXES   = 6;
    localparam int AXIS_W = $clog2(AXES);

    // Gain division: one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    typedef enum logic {
        REG_PROCESS_NOISE     = 1'b0,
        REG_MEASUREMENT_NOISE = 1'b1
    } cfg_index_t;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PRED = 9'b000000010,
        ST_DIV  = 9'b000000100,
        ST_DIFF = 9'b000001000,
        ST_MUL  = 9'b000010000,
        ST_ACC  = 9'b000100000,
        ST_VMUL = 9'b001000000,
        ST_VUPD = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic        start;
        logic [31:0] numer;
        logic [32:0] denom;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

@@ src/sck_div.sv @@
// Bit-serial restoring divider for the Kalman gain: floor(numer * 2^32 / denom).
// Depends on sck_pkg. Zero divisor gives zero; a full-scale quotient saturates.
module sck_div import sck_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [32:0]          rem_reg;
    logic [32:0]          den_reg;
    logic [31:0]          quo_reg;

    logic [33:0] trial;
    logic        fits;
    logic [33:0] diff;
    logic [32:0] rem_next;

    // One shift-compare-subtract step
    always_comb begin
        trial    = {rem_reg, 1'b0};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[32:0] : trial[32:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= {1'b0, req.numer};
            den_reg <= req.denom;
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = (den_reg == '0) ? '0 : quo_reg;

endmodule

@@ src/six_channel_kalman_smoother.sv @@
// Top level of the six-channel Kalman smoother (identity model, shared variance).
// Depends on sck_pkg and sck_div.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  input     | s_valid / s_ready  | s_meas_{force,torque}_{x,y,z}, Q16.16
//  result    | m_valid / m_ready  | m_est_{force,torque}_{x,y,z}, Q16.16
//  config    | cfg_wr_en          | cfg_index, cfg_wdata (no read-back)
//
// After an input beat, m_valid rises once the block has formed p + q, run the
// bit-serial gain division, passed each axis through the one shared 32x32 multiplier,
// updated the variance and loaded the result register.
// s_ready is high only in idle; it returns as the result is loaded, so the
// next beat can enter while the previous result still waits for m_ready.
// Reset is synchronous: estimates clear, variance and noise registers go to 1.0.
module six_channel_kalman_smoother import sck_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // input beat
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_meas_force_x,
    input  logic [31:0] s_meas_force_y,
    input  logic [31:0] s_meas_force_z,
    input  logic [31:0] s_meas_torque_x,
    input  logic [31:0] s_meas_torque_y,
    input  logic [31:0] s_meas_torque_z,
    // result beat
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_est_force_x,
    output logic [31:0] m_est_force_y,
    output logic [31:0] m_est_force_z,
    output logic [31:0] m_est_torque_x,
    output logic [31:0] m_est_torque_y,
    output logic [31:0] m_est_torque_z
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    logic [31:0]       q_reg;
    logic [31:0]       r_reg;
    logic [31:0]       p_reg;
    logic [31:0]       x_reg   [AXES];
    logic [31:0]       z_reg   [AXES];
    logic [31:0]       out_reg [AXES];
    logic [AXIS_W-1:0] idx_reg;
    logic [31:0]       pp_reg;
    logic [31:0]       gain_reg;
    logic [31:0]       mag_reg;
    logic              neg_reg;
    logic [63:0]       prod_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic        in_beat;
    logic        load_out;
    logic [32:0] pp_sum;
    logic [31:0] pp_sat;
    logic [32:0] diff;
    logic [32:0] neg_diff;
    logic [31:0] mag_next;
    logic [63:0] mul_out;
    logic [32:0] dm;
    logic [33:0] delta;
    logic [33:0] sum;
    logic [31:0] x_next;
    logic [32:0] dec;
    logic [32:0] newp;
    logic [31:0] p_next;

    assign in_beat  = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Predicted variance, saturated at full scale
    always_comb begin
        pp_sum = {1'b0, p_reg} + {1'b0, q_reg};
        pp_sat = pp_sum[32] ? '1 : pp_sum[31:0];
    end

    // Gain division request, issued in the predict cycle
    assign div_req.start = (state_reg == ST_PRED);
    assign div_req.numer = pp_sat;
    assign div_req.denom = {1'b0, pp_sat} + {1'b0, r_reg};

    sck_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Innovation magnitude of the current axis
    always_comb begin
        diff     = {z_reg[idx_reg][31], z_reg[idx_reg]} - {x_reg[idx_reg][31], x_reg[idx_reg]};
        neg_diff = 33'd0 - diff;
        mag_next = diff[32] ? neg_diff[31:0] : diff[31:0];
    end

    // Shared multiplier: magnitude times gain, or variance times gain
    assign mul_out = 64'(mag_reg) * 64'(gain_reg);

    // Rounded correction, half away from zero, and saturated estimate
    always_comb begin
        dm    = {1'b0, prod_reg[63:32]} + 33'(prod_reg[31]);
        delta = neg_reg ? (34'd0 - {1'b0, dm}) : {1'b0, dm};
        sum   = {{2{x_reg[idx_reg][31]}}, x_reg[idx_reg]} + delta;
        if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
            x_next = sum[31:0];
        end else if (sum[33]) begin
            x_next = 32'h8000_0000;
        end else begin
            x_next = 32'h7FFF_FFFF;
        end
    end

    // New variance: pp - ceil(gain * pp / 2^32), clamped to r
    always_comb begin
        dec    = {1'b0, prod_reg[63:32]} + 33'(|prod_reg[31:0]);
        newp   = {1'b0, pp_reg} - dec;
        p_next = (newp[31:0] > r_reg) ? r_reg : newp[31:0];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_beat) state_next = ST_PRED;
            ST_PRED: state_next = ST_DIV;
            ST_DIV:  if (div_rsp.done) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC: begin
                if (idx_reg == AXIS_W'(AXES - 1)) begin
                    state_next = ST_VMUL;
                end else begin
                    state_next = ST_DIFF;
                end
            end
            ST_VMUL: state_next = ST_VUPD;
            ST_VUPD: state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control, filter state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            p_reg       <= ONE_Q;
            q_reg       <= ONE_Q;
            r_reg       <= ONE_Q;
            for (int i = 0; i < AXES; i++) begin
                x_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PROCESS_NOISE:     q_reg <= cfg_wdata;
                    REG_MEASUREMENT_NOISE: r_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_beat) begin
                idx_reg <= '0;
            end
            if (state_reg == ST_ACC) begin
                x_reg[idx_reg] <= x_next;
                idx_reg        <= idx_reg + 1'b1;
            end
            if (state_reg == ST_VUPD) begin
                p_reg <= p_next;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            z_reg[0] <= s_meas_force_x;
            z_reg[1] <= s_meas_force_y;
            z_reg[2] <= s_meas_force_z;
            z_reg[3] <= s_meas_torque_x;
            z_reg[4] <= s_meas_torque_y;
            z_reg[5] <= s_meas_torque_z;
        end
        case (state_reg)
            ST_PRED: pp_reg <= pp_sat;
            ST_DIV:  gain_reg <= div_rsp.quotient;
            ST_DIFF: begin
                mag_reg <= mag_next;
                neg_reg <= diff[32];
            end
            ST_MUL:  prod_reg <= mul_out;
            ST_ACC:  mag_reg <= pp_reg;
            ST_VMUL: prod_reg <= mul_out;
            default: ;
        endcase
        if (load_out) begin
            for (int i = 0; i < AXES; i++) begin
                out_reg[i] <= x_reg[i];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_est_force_x  = out_reg[0];
    assign m_est_force_y  = out_reg[1];
    assign m_est_force_z  = out_reg[2];
    assign m_est_torque_x = out_reg[3];
    assign m_est_torque_y = out_reg[4];
    assign m_est_torque_z = out_reg[5];

endmodule

@@ src/sck_checker.sv @@
// Port-level checker for six_channel_kalman_smoother, bound to the top level.
// Depends on six_channel_kalman_smoother_macros.svh.
`include "six_channel_kalman_smoother_macros.svh"

module sck_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_est_force_x
);

    // A stalled result beat stays valid
    `SCK_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result beat dropped while stalled")

    // A stalled result beat keeps its force x payload
    `SCK_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_est_force_x), "stalled result changed")

    // One sample at a time: busy right after an input beat
    `SCK_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready, "input taken while busy")

    // No result appears in the cycle after an input beat
    `SCK_ASSERT_NEXT(a_no_early_out, s_valid && s_ready, !$rose(m_valid), "result too early")

endmodule

bind six_channel_kalman_smoother sck_checker u_sck_checker (.*);

@@ tb/tb_six_channel_kalman_smoother.sv @@
// Self-checking testbench for six_channel_kalman_smoother.
// Holds its own shared-variance Kalman predictor and a queue of expected estimates.
// Depends on sck_pkg and the RTL of the block only.
module tb_six_channel_kalman_smoother;
    import sck_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One beat of six axes, force x in the low word up to torque z in the high word
    typedef logic [AXES-1:0][31:0] axes_t;

    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;
    localparam logic [31:0] Q_POS_RAIL = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_RAIL = 32'h8000_0000;
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam logic [31:0] Q_ALL_ONES = 32'hFFFF_FFFF;

    localparam int unsigned RAND_PHASES      = 6;
    localparam int unsigned ITEMS_PER_PHASE  = 300;
    localparam int unsigned LONG_HOLD_AT     = 40;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES      = 100;

    // Predicts the estimates per sample and queues them until the result beat shows up
    class smoother_scoreboard;
        longint      est [AXES];
        logic [31:0] variance;
        logic [31:0] q_noise;
        logic [31:0] r_noise;
        axes_t       pending_estimates [$];
        string       field_name [AXES];
        int          errors;

        function new();
            for (int a = 0; a < AXES; a++) est[a] = 0;
            variance = Q_ONE;
            q_noise  = Q_ONE;
            r_noise  = Q_ONE;
            errors   = 0;
            field_name = '{"est_force_x", "est_force_y", "est_force_z",
                           "est_torque_x", "est_torque_y", "est_torque_z"};
        endfunction

        function void set_register(cfg_index_t idx, logic [31:0] value);
            if (idx == REG_PROCESS_NOISE) q_noise = value;
            else r_noise = value;
        endfunction

        // One filter update: shared gain, per-axis correction, variance shrink
        function axes_t filter_step(axes_t meas);
            longint unsigned p_pred, denom, gain, mag, delta_mag, p_next;
            longint          diff, total;
            axes_t           outv;
            p_pred = 64'(variance) + 64'(q_noise);
            if (p_pred > 64'hFFFF_FFFF) p_pred = 64'hFFFF_FFFF;
            denom = p_pred + 64'(r_noise);
            // zero divisor gives zero gain; quotient of one saturates
            if (denom == 0) begin
                gain = 0;
            end else begin
                gain = (p_pred << 32) / denom;
                if (gain > 64'hFFFF_FFFF) gain = 64'hFFFF_FFFF;
            end
            for (int a = 0; a < AXES; a++) begin
                diff = longint'($signed(meas[a])) - est[a];
                mag  = (diff < 0) ? -diff : diff;
                // magnitude rounded half away from zero at 2^-32
                delta_mag = (mag * gain + 64'h8000_0000) >> 32;
                total = (diff < 0) ? est[a] - longint'(delta_mag)
                                   : est[a] + longint'(delta_mag);
                if (total > EST_MAX) total = EST_MAX;
                else if (total < EST_MIN) total = EST_MIN;
                est[a]  = total;
                outv[a] = 32'(total);
            end
            p_next = ((64'h1_0000_0000 - gain) * p_pred) >> 32;
            if (p_next > 64'(r_noise)) p_next = 64'(r_noise);
            variance = 32'(p_next);
            return outv;
        endfunction

        function void note_sample(axes_t meas);
            pending_estimates.push_back(filter_step(meas));
        endfunction

        function void check_estimate(axes_t got);
            axes_t want;
            if (pending_estimates.size() == 0) begin
                $error("result beat with no sample outstanding");
                errors++;
                return;
            end
            want = pending_estimates.pop_front();
            for (int a = 0; a < AXES; a++) begin
                if (got[a] !== want[a]) begin
                    $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", field_name[a],
                           $signed(want[a]), want[a], $signed(got[a]), got[a]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_estimates.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_meas_force_x, s_meas_force_y, s_meas_force_z;
    logic [31:0] s_meas_torque_x, s_meas_torque_y, s_meas_torque_z;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_est_force_x, m_est_force_y, m_est_force_z;
    logic [31:0] m_est_torque_x, m_est_torque_y, m_est_torque_z;

    bit tx_idle_en;
    bit rx_idle_en;

    smoother_scoreboard sb = new();

    six_channel_kalman_smoother DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_meas_force_x  (s_meas_force_x),
        .s_meas_force_y  (s_meas_force_y),
        .s_meas_force_z  (s_meas_force_z),
        .s_meas_torque_x (s_meas_torque_x),
        .s_meas_torque_y (s_meas_torque_y),
        .s_meas_torque_z (s_meas_torque_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_est_force_x   (m_est_force_x),
        .m_est_force_y   (m_est_force_y),
        .m_est_force_z   (m_est_force_z),
        .m_est_torque_x  (m_est_torque_x),
        .m_est_torque_y  (m_est_torque_y),
        .m_est_torque_z  (m_est_torque_z)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hang guard
    initial begin : watchdog
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check each beat, random short stalls, one long hold to back up the block
    initial begin : result_sink
        int unsigned stall;
        int unsigned n_results;
        bit          long_hold_done;
        stall          = 0;
        n_results      = 0;
        long_hold_done = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else begin
                if (m_valid && m_ready) begin
                    sb.check_estimate({m_est_torque_z, m_est_torque_y, m_est_torque_x,
                                       m_est_force_z, m_est_force_y, m_est_force_x});
                    n_results++;
                end
                if (!long_hold_done && n_results == LONG_HOLD_AT) begin
                    stall          = LONG_HOLD_CYCLES;
                    long_hold_done = 1;
                end else if (stall == 0 && rx_idle_en && $urandom_range(0, 7) == 0) begin
                    stall = $urandom_range(1, 3);
                end
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    stall--;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    function automatic axes_t fill(logic [31:0] word);
        axes_t v;
        for (int a = 0; a < AXES; a++) v[a] = word;
        return v;
    endfunction

    // Offer one beat (after an optional gap) and return at the edge that takes it
    task automatic send_sample(axes_t smp);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_meas_torque_z, s_meas_torque_y, s_meas_torque_x,
         s_meas_force_z, s_meas_force_y, s_meas_force_x} <= smp;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(smp);
    endtask

    // Stop offering and wait until every expected estimate has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Both noise registers, one per edge; only called with the block idle
    task automatic set_noise(logic [31:0] q, logic [31:0] r);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PROCESS_NOISE;
        cfg_wdata <= q;
        @(posedge aclk);
        cfg_index <= REG_MEASUREMENT_NOISE;
        cfg_wdata <= r;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(REG_PROCESS_NOISE, q);
        sb.set_register(REG_MEASUREMENT_NOISE, r);
    endtask

    task automatic pick_noise(output logic [31:0] q, output logic [31:0] r);
        case ($urandom_range(0, 4))
            0, 1: begin
                q = $urandom_range(0, 32'h0004_0000);
                r = $urandom_range(1, 32'h0040_0000);
            end
            2: begin
                q = $urandom;
                r = $urandom_range(1, 32'h0001_0000);
            end
            3: begin
                q = $urandom_range(0, 32'h100);
                r = $urandom | 32'h8000_0000;
            end
            default: begin
                q = $urandom;
                r = $urandom;
                if (r == 0) r = 1;
            end
        endcase
    endtask

    // Runs of noisy steady levels with steps, mixed with raw words and rail values
    task automatic random_phase(int unsigned n_items);
        axes_t       level, smp;
        int unsigned kind, run_len, sent, span;
        sent = 0;
        while (sent < n_items) begin
            kind    = $urandom_range(0, 9);
            run_len = $urandom_range(8, 40);
            for (int a = 0; a < AXES; a++)
                level[a] = $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000;
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                for (int a = 0; a < AXES; a++) begin
                    if (kind <= 6) begin
                        if ($urandom_range(0, 31) == 0) level[a] = $urandom;
                        span   = 1 << $urandom_range(0, 20);
                        smp[a] = level[a] + $urandom_range(0, 2 * span) - span;
                    end else if (kind <= 8) begin
                        smp[a] = $urandom;
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       smp[a] = Q_POS_RAIL;
                            1:       smp[a] = Q_NEG_RAIL;
                            2:       smp[a] = '0;
                            default: smp[a] = Q_ALL_ONES;
                        endcase
                    end
                end
                send_sample(smp);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        logic [31:0] q, r;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_PROCESS_NOISE;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        {s_meas_torque_z, s_meas_torque_y, s_meas_torque_x,
         s_meas_force_z, s_meas_force_y, s_meas_force_x} <= '0;
        tx_idle_en = 1;
        rx_idle_en = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Unit noise: zero, rails, near-zero words and mixed signs
        set_noise(Q_ONE, Q_ONE);
        send_sample(fill('0));
        send_sample(fill(Q_POS_RAIL));
        send_sample(fill(Q_NEG_RAIL));
        send_sample(fill(Q_POS_RAIL));
        send_sample(fill(Q_ALL_ONES));
        send_sample(fill(32'h0000_0001));
        send_sample({Q_POS_RAIL, 32'h0000_0001, Q_ALL_ONES, 32'h0, Q_NEG_RAIL, Q_POS_RAIL});
        send_sample({Q_NEG_RAIL, Q_ALL_ONES, 32'h0000_0001, Q_POS_RAIL, Q_POS_RAIL, Q_NEG_RAIL});
        drain();

        // Huge process noise, minimum measurement noise: p + q saturates, gain near one
        set_noise(Q_ALL_ONES, 32'h0000_0001);
        send_sample(fill(Q_POS_RAIL));
        send_sample(fill(Q_NEG_RAIL));
        send_sample(fill(Q_POS_RAIL));
        drain();

        // Both noises zero: saturated gain first, then a zero divisor
        set_noise('0, '0);
        send_sample(fill(Q_NEG_RAIL));
        send_sample(fill(Q_ONE));
        send_sample(fill(Q_POS_RAIL));
        drain();

        // Zero measurement noise with large process noise
        set_noise(Q_ALL_ONES, '0);
        send_sample(fill(Q_NEG_RAIL));
        send_sample(fill('0));
        drain();

        // No process noise, maximum measurement noise: tiny gain
        set_noise('0, Q_ALL_ONES);
        send_sample(fill(Q_POS_RAIL));
        send_sample(fill(Q_NEG_RAIL));
        drain();

        // Random settings; last phase runs without idling on either side
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            pick_noise(q, r);
            if (ph == RAND_PHASES - 1) begin
                tx_idle_en = 0;
                rx_idle_en = 0;
            end
            set_noise(q, r);
            random_phase(ITEMS_PER_PHASE);
            drain();
        end

        // Let any stray beat surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ six_channel_kalman_smoother.f @@
+incdir+src
src/sck_pkg.sv
src/sck_div.sv
src/six_channel_kalman_smoother.sv
src/sck_checker.sv
tb/tb_six_channel_kalman_smoother.sv
